// File: sv/som_pkg.sv
package som_pkg;

   localparam int MaxNeurons = 256;
   localparam int MaxDim = 16;
   localparam int LabelBits = 4;
   localparam int NeuronBits = 8;
   localparam int DimBits = 4;
   localparam int WeightDepth = MaxNeurons * MaxDim;
   localparam int WeightAddrBits = NeuronBits + DimBits;
   localparam int DistBits = 40;
   localparam logic [15:0] TallyMax = 16'hFFFF;

   typedef enum logic [1:0] {
      CMD_LOAD_WEIGHT = 2'd0,
      CMD_LOAD_LABEL  = 2'd1,
      CMD_PATTERN     = 2'd2,
      CMD_CLEAR       = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      OUT_CORRECT      = 2'd0,
      OUT_MISCLASSIFIED = 2'd1,
      OUT_UNCLASSIFIED = 2'd2
   } outcome_type;

   localparam logic [1:0] RegNeuronCount = 2'd0;
   localparam logic [1:0] RegVectorLength = 2'd1;

endpackage

// File: sv/som_classifier.sv
// som_bmu_classifier: load commands and non-final pattern components are
// accepted while idle. A final pattern component starts the search: the weight
// memory is read one word per cycle over neurons in use times vector length
// words (pruned neurons are still swept), then the pipeline drains and the
// label lookup and report follow, for a map of up to 256 x 16. A zero vector
// length sweeps one word per neuron in use; a zero neuron count skips the sweep
// and goes to the label and report states. A clearing pass after reset zeroes
// all 256 entries of the label and prune memory; no transaction is accepted
// until it ends. The result stays in an output register until taken; the next
// transaction is accepted meanwhile only if it produces no result.
module som_bmu_classifier
   import som_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_neuron_index,
   input  logic [3:0]  req_component_index,
   input  logic signed [15:0] req_component_value,
   input  logic [3:0]  req_label_code,
   input  logic        req_pruned_flag,
   input  logic        req_last_component,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_winner_found,
   output logic [7:0]  rsp_winner_index,
   output logic [3:0]  rsp_winner_label,
   output logic [1:0]  rsp_outcome,
   output logic [15:0] rsp_error_tally,
   output logic [15:0] rsp_misclassified_tally,
   output logic [15:0] rsp_unclassified_tally,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_SWEEP  = 6'b000100,
      ST_DRAIN  = 6'b001000,
      ST_LABEL  = 6'b010000,
      ST_REPORT = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [8:0] neuron_count_ff;
   logic [4:0] vector_length_ff;
   logic       csr_write;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         neuron_count_ff <= 9'd256;
         vector_length_ff <= 5'd16;
      end else if (csr_write) begin
         if (csr_paddr[2] == RegVectorLength[0]) begin
            vector_length_ff <= csr_pwdata[4:0];
         end else begin
            neuron_count_ff <= csr_pwdata[8:0];
         end
      end
   end

   always_comb begin
      case (csr_paddr[2])
         RegNeuronCount[0]: csr_prdata = {23'd0, neuron_count_ff};
         default:           csr_prdata = {27'd0, vector_length_ff};
      endcase
   end

   logic [8:0] count_lim;
   logic [4:0] len_lim;
   logic [4:0] len_eff;
   assign count_lim = (neuron_count_ff > 9'(MaxNeurons)) ? 9'(MaxNeurons) : neuron_count_ff;
   assign len_lim = (vector_length_ff > 5'(MaxDim)) ? 5'(MaxDim) : vector_length_ff;
   assign len_eff = (len_lim == 5'd0) ? 5'd1 : len_lim;

   logic accept;
   logic is_search;
   assign accept = req_valid && req_ready;
   assign is_search = (req_cmd == CMD_PATTERN) && req_last_component;
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid || !is_search);

   // Pattern buffer: small register file, written per component.
   logic signed [15:0] pattern_ff [MaxDim];
   logic [3:0]         pat_label_ff;
   always_ff @(posedge clock) begin
      if (accept && req_cmd == CMD_PATTERN) begin
         pattern_ff[req_component_index] <= req_component_value;
         if (req_last_component) begin
            pat_label_ff <= req_label_code;
         end
      end
   end

   // Sweep counters.
   logic [7:0] n_ff, n_in;
   logic [3:0] c_ff, c_in;
   logic       sweep_last;
   logic       comp_last;
   logic [8:0] clr_ff;
   assign comp_last = ({1'b0, c_ff} + 5'd1 == len_eff);
   assign sweep_last = comp_last && ({1'b0, n_ff} + 9'd1 == count_lim);

   // Zero length: every distance is zero, first unpruned neuron wins. That
   // case is settled by a one-word sweep per neuron with a forced zero square.
   logic zero_len_ff;

   // Weight memory.
   logic        w_we;
   logic [11:0] w_rd_addr;
   logic signed [15:0] w_rd;
   assign w_we = accept && req_cmd == CMD_LOAD_WEIGHT;
   assign w_rd_addr = {n_ff, c_ff};

   som_ram #(.Width(16), .Depth(WeightDepth)) u_weight (
      .clock   (clock),
      .wr_en   (w_we),
      .wr_addr ({req_neuron_index, req_component_index}),
      .wr_data (req_component_value),
      .rd_addr (w_rd_addr),
      .rd_data (w_rd)
   );

   // Label and prune memory: {pruned, label}.
   logic       lp_we;
   logic [7:0] lp_wr_addr, lp_rd_addr;
   logic [4:0] lp_wr_data, lp_rd;
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         lp_we = 1'b1;
         lp_wr_addr = clr_ff[7:0];
         lp_wr_data = 5'd0;
      end else begin
         lp_we = accept && req_cmd == CMD_LOAD_LABEL;
         lp_wr_addr = req_neuron_index;
         lp_wr_data = {req_pruned_flag, req_label_code};
      end
   end

   logic [7:0] best_ff, best_in;
   assign lp_rd_addr = (state_ff == ST_SWEEP) ? n_ff : best_ff;

   som_ram #(.Width(5), .Depth(MaxNeurons)) u_label (
      .clock   (clock),
      .wr_en   (lp_we),
      .wr_addr (lp_wr_addr),
      .wr_data (lp_wr_data),
      .rd_addr (lp_rd_addr),
      .rd_data (lp_rd)
   );

   // Pipeline: stage 1 holds the read data tag, stage 2 the square.
   logic       s1_v_ff, s1_first_ff, s1_end_ff;
   logic [3:0] s1_c_ff;
   logic [7:0] s1_n_ff;
   logic       s2_v_ff, s2_first_ff, s2_end_ff, s2_pruned_ff;
   logic [7:0] s2_n_ff;
   logic [33:0] sq_ff;
   logic signed [16:0] diff;
   assign diff = 17'(w_rd) - 17'(pattern_ff[s1_c_ff]);

   logic [DistBits-1:0] acc_ff, best_dist_ff, dist_now;
   logic                found_ff, found_in;
   logic [DistBits-1:0] best_dist_in;
   assign dist_now = (s2_first_ff ? '0 : acc_ff) + DistBits'(sq_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= state_ff == ST_SWEEP;
         s2_v_ff <= s1_v_ff;
      end
      s1_first_ff <= c_ff == 4'd0;
      s1_end_ff <= comp_last;
      s1_c_ff <= c_ff;
      s1_n_ff <= n_ff;
      s2_first_ff <= s1_first_ff;
      s2_end_ff <= s1_end_ff;
      s2_n_ff <= s1_n_ff;
      s2_pruned_ff <= lp_rd[4];
      sq_ff <= zero_len_ff ? 34'd0 : 34'($signed(diff) * $signed(diff));
      if (s2_v_ff) begin
         acc_ff <= dist_now;
      end
   end

   always_comb begin
      found_in = found_ff;
      best_in = best_ff;
      best_dist_in = best_dist_ff;
      if (state_ff == ST_IDLE) begin
         found_in = 1'b0;
         best_in = '0;
      end else if (s2_v_ff && s2_end_ff && !s2_pruned_ff &&
                   (!found_ff || dist_now < best_dist_ff)) begin
         found_in = 1'b1;
         best_in = s2_n_ff;
         best_dist_in = dist_now;
      end
   end

   always_ff @(posedge clock) begin
      found_ff <= found_in;
      best_ff <= best_in;
      best_dist_ff <= best_dist_in;
   end

   // Sequencer.
   logic [1:0] drain_ff;
   always_comb begin
      state_in = state_ff;
      n_in = n_ff;
      c_in = c_ff;
      case (state_ff)
         ST_CLEAR: if (clr_ff == 9'(MaxNeurons - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            n_in = '0;
            c_in = '0;
            if (accept && is_search) begin
               if (count_lim == 9'd0) state_in = ST_LABEL;
               else state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (sweep_last) begin
               state_in = ST_DRAIN;
            end else if (comp_last) begin
               c_in = '0;
               n_in = n_ff + 8'd1;
            end else begin
               c_in = c_ff + 4'd1;
            end
         end
         ST_DRAIN: if (drain_ff == 2'd2) state_in = ST_LABEL;
         ST_LABEL: state_in = ST_REPORT;
         ST_REPORT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         n_ff <= '0;
         c_ff <= '0;
         drain_ff <= '0;
         zero_len_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         n_ff <= n_in;
         c_ff <= c_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + 9'd1;
         drain_ff <= (state_ff == ST_DRAIN) ? drain_ff + 2'd1 : 2'd0;
         if (state_ff == ST_IDLE) zero_len_ff <= len_lim == 5'd0;
      end
   end

   // Outcome and tallies.
   logic [3:0]  wlabel;
   outcome_type outcome;
   logic [15:0] err_ff, mis_ff, unc_ff;
   assign wlabel = found_ff ? lp_rd[3:0] : 4'd0;
   always_comb begin
      if (!found_ff) outcome = OUT_UNCLASSIFIED;
      else if (wlabel == pat_label_ff) outcome = OUT_CORRECT;
      else if (wlabel == 4'd0) outcome = OUT_UNCLASSIFIED;
      else outcome = OUT_MISCLASSIFIED;
   end

   logic report;
   assign report = state_ff == ST_REPORT;

   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff <= '0;
         mis_ff <= '0;
         unc_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         if (accept && req_cmd == CMD_CLEAR) begin
            err_ff <= '0;
            mis_ff <= '0;
            unc_ff <= '0;
         end else if (report) begin
            if (outcome != OUT_CORRECT && err_ff != TallyMax) err_ff <= err_ff + 16'd1;
            if (outcome == OUT_MISCLASSIFIED && mis_ff != TallyMax) mis_ff <= mis_ff + 16'd1;
            if (outcome == OUT_UNCLASSIFIED && unc_ff != TallyMax) unc_ff <= unc_ff + 16'd1;
         end
         if (report) rsp_valid <= 1'b1;
         else if (rsp_ready) rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (report) begin
         rsp_winner_found <= found_ff;
         rsp_winner_index <= found_ff ? best_ff : 8'd0;
         rsp_winner_label <= wlabel;
         rsp_outcome <= outcome;
         rsp_error_tally <= (outcome != OUT_CORRECT && err_ff != TallyMax) ?
                            err_ff + 16'd1 : err_ff;
         rsp_misclassified_tally <= (outcome == OUT_MISCLASSIFIED && mis_ff != TallyMax) ?
                                    mis_ff + 16'd1 : mis_ff;
         rsp_unclassified_tally <= (outcome == OUT_UNCLASSIFIED && unc_ff != TallyMax) ?
                                   unc_ff + 16'd1 : unc_ff;
      end
   end

endmodule

// File: sv/som_ram.sv
module som_ram #(
   parameter int Width = 16,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: sv/som_checker.sv
module som_checker
   import som_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_outcome,
   input logic       rsp_winner_found,
   input logic [15:0] rsp_error_tally
);

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid)
      else $error("request withdrawn before acceptance");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_outcome))
      else $error("result dropped while stalled");

   a_nofound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_winner_found |-> rsp_outcome == OUT_UNCLASSIFIED)
      else $error("no winner but not unclassified");

   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_outcome == OUT_CORRECT || rsp_outcome == OUT_MISCLASSIFIED ||
                    rsp_outcome == OUT_UNCLASSIFIED)
      else $error("bad outcome code");

   a_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outcome != OUT_CORRECT |-> rsp_error_tally != 16'd0)
      else $error("error tally not counted");

endmodule

bind som_bmu_classifier som_checker u_som_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_outcome(rsp_outcome),
   .rsp_winner_found(rsp_winner_found), .rsp_error_tally(rsp_error_tally)
);
